// File: rtl/wba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wba_pkg - shared types and constants of the buffer allocator
// Field widths, operation and status codes, sequencer states, default sizes.
// ---------------------------------------------------------------------------
package wba_pkg;

   // default sizes handed to the top level
   localparam int CHANNELS_DEF    = 8;
   localparam int BUFFERS_DEF     = 4;
   localparam int COUNT_WIDTH_DEF = 8;

   // port field widths
   localparam int OP_W     = 1;
   localparam int CHAN_W   = 3;
   localparam int IDX_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 3;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_ACQUIRE = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNHELD = 2'd2;

   // register map (word index taken from paddr[2])
   localparam logic REG_BUFFERS_IN_USE = 1'b0;
   localparam logic [CFG_W-1:0] BUFFERS_IN_USE_RESET = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage
`default_nettype wire

// File: rtl/wba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wba_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module wba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/wba_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wba_scan - age order scan unit
// Examines one age order entry per step, oldest first, and keeps the oldest
// free active buffer, the two newest active buffers and the target position.
// ---------------------------------------------------------------------------
module wba_scan #(
   parameter int BUFFERS = wba_pkg::BUFFERS_DEF,
   localparam int BUF_W = $clog2(BUFFERS),
   localparam int NW = BUF_W + 2
) (
   input  wire logic                  clock,
   input  wire wba_pkg::scan_ctl_type ctl,
   input  wire logic [NW-1:0]         active_n,
   input  wire logic [BUF_W-1:0]      entry_pos,
   input  wire logic [BUF_W-1:0]      entry_buf,
   input  wire logic                  entry_zero,
   input  wire logic [BUF_W-1:0]      target_buf,
   output logic                       free_found,
   output logic      [BUF_W-1:0]      free_buf,
   output logic      [BUF_W-1:0]      free_pos,
   output logic      [BUF_W-1:0]      newest_buf,
   output logic      [BUF_W-1:0]      second_buf,
   output logic                       newest_zero,
   output logic      [BUF_W-1:0]      match_pos
);

   logic             found_ff;
   logic [BUF_W-1:0] free_buf_ff;
   logic [BUF_W-1:0] free_pos_ff;
   logic [BUF_W-1:0] newest_ff;
   logic [BUF_W-1:0] second_ff;
   logic             newest_zero_ff;
   logic [BUF_W-1:0] match_pos_ff;
   logic             active;

   // rotation set compare: is this buffer in the rotation set
   assign active = NW'(entry_buf) < active_n;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         found_ff       <= 1'b0;
         free_buf_ff    <= '0;
         free_pos_ff    <= '0;
         newest_ff      <= '0;
         second_ff      <= '0;
         newest_zero_ff <= 1'b0;
         match_pos_ff   <= '0;
      end else if (ctl.step) begin
         if (active && entry_zero && !found_ff) begin
            found_ff    <= 1'b1;
            free_buf_ff <= entry_buf;
            free_pos_ff <= entry_pos;
         end
         if (active) begin
            second_ff      <= newest_ff;
            newest_ff      <= entry_buf;
            newest_zero_ff <= entry_zero;
         end
         if (entry_buf == target_buf) begin
            match_pos_ff <= entry_pos;
         end
      end
   end

   assign free_found  = found_ff;
   assign free_buf    = free_buf_ff;
   assign free_pos    = free_pos_ff;
   assign newest_buf  = newest_ff;
   assign second_buf  = second_ff;
   assign newest_zero = newest_zero_ff;
   assign match_pos   = match_pos_ff;

endmodule
`default_nettype wire

// File: rtl/waitfree_buffer_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// waitfree_buffer_allocator_core - per-channel buffer allocator
// Grants and releases buffers of single-writer wait-free channels.
// ---------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one acquire or release per transfer. The block
//    stalls the request side while it works on an item.
//  - Result channel (rsp_*): one result transfer per request, in order.
//  - CSR port (csr_*): APB-style, register buffers_in_use at byte address 0.
//    Write it only while the block is idle.
//  - Sequence: for a channel in range the request goes through fetch row,
//    load row, a scan of one age order position per cycle through the
//    shared scan unit, update and hand off. A request for a channel out
//    of range goes straight to hand off.
//  - Overlap: a new request is taken only after the last item is handed
//    off; the per-position scan of the age order sets the time per item.
//  - Reset clears all row valid bits, so every channel reads as identity
//    order with zero holders until first written; no clearing pass runs.
//  - A stalled result holds in the output register; the block finishes the
//    next item up to hand-off and waits there until the register frees.
// ---------------------------------------------------------------------------
module waitfree_buffer_allocator_core #(
   parameter int CHANNELS    = wba_pkg::CHANNELS_DEF,
   parameter int BUFFERS     = wba_pkg::BUFFERS_DEF,
   parameter int COUNT_WIDTH = wba_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [wba_pkg::OP_W-1:0]       req_operation,
   input  wire logic [wba_pkg::CHAN_W-1:0]     req_channel,
   input  wire logic                           req_is_writer,
   input  wire logic                           req_has_written,
   input  wire logic [wba_pkg::IDX_W-1:0]      req_held_buffer,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [wba_pkg::IDX_W-1:0]      rsp_buffer_index,
   output logic      [wba_pkg::STATUS_W-1:0]   rsp_status,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [wba_pkg::ADDR_W-1:0]     csr_paddr,
   input  wire logic [wba_pkg::DATA_W-1:0]     csr_pwdata,
   output logic      [wba_pkg::DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int BUF_W    = $clog2(BUFFERS);
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NW       = BUF_W + 2;
   localparam int ORDER_W  = BUFFERS * BUF_W;
   localparam int COUNTS_W = BUFFERS * COUNT_WIDTH;
   localparam int ROW_W    = ORDER_W + COUNTS_W;
   localparam int IDX_W    = wba_pkg::IDX_W;
   localparam int STATUS_W = wba_pkg::STATUS_W;
   localparam int CFG_W    = wba_pkg::CFG_W;
   localparam int DATA_W   = wba_pkg::DATA_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [BUF_W-1:0]       LAST_POS  = BUF_W'(BUFFERS - 1);

   typedef logic [BUFFERS-1:0][BUF_W-1:0]       order_row_type;
   typedef logic [BUFFERS-1:0][COUNT_WIDTH-1:0] count_row_type;

   // ------------------------------------------------------------------
   // sequencer state and control
   // ------------------------------------------------------------------
   wba_pkg::state_type    state_ff, state_in;
   wba_pkg::scan_ctl_type scan_ctl;
   logic accept;
   logic ram_rd_en;
   logic load_row;
   logic upd;
   logic out_load;
   logic chan_ok_req;

   // captured request
   logic [wba_pkg::OP_W-1:0]   op_ff;
   logic [wba_pkg::CHAN_W-1:0] chan_ff;
   logic                       writer_ff;
   logic                       written_ff;
   logic [IDX_W-1:0]           held_ff;

   // configuration
   logic [CFG_W-1:0] cfg_ff;
   logic [NW-1:0]    active_n;
   logic             cfg_write;

   // working copy of one channel row
   logic [CHANNELS-1:0] row_valid_ff;
   order_row_type       order_ff, order_reset, new_order;
   count_row_type       count_ff, new_count;
   logic [BUF_W-1:0]    pos_ff;
   logic [CH_W-1:0]     ch_addr;
   logic [CH_W+2:0]     chan_wide;
   logic [ROW_W-1:0]    ram_rd_data, ram_wr_data;

   // scan results
   logic             free_found, newest_zero;
   logic [BUF_W-1:0] free_buf, free_pos, newest_buf, second_buf, match_pos;

   // update datapath
   logic [BUF_W-1:0]       entry_buf;
   logic [BUF_W-1:0]       cnt_addr, upd_sel, reader_idx, held_b, move_pos;
   logic [BUF_W+1:0]       held_wide, sel_wide;
   logic [COUNT_WIDTH-1:0] cnt_rd, new_cnt;
   logic                   held_ok, wr_req, is_acq;
   logic                   do_bump, do_dec, do_move;
   logic [IDX_W-1:0]       upd_idx;
   logic [STATUS_W-1:0]    upd_status;

   // result registers
   logic [IDX_W-1:0]    res_idx_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   assign req_stall   = (state_ff != wba_pkg::ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign chan_ok_req = (CH_W + 4)'(req_channel) < (CH_W + 4)'(CHANNELS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wba_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = chan_ok_req ? wba_pkg::ST_FETCH : wba_pkg::ST_FINISH;
            end
         end
         wba_pkg::ST_FETCH:  state_in = wba_pkg::ST_LOAD;
         wba_pkg::ST_LOAD:   state_in = wba_pkg::ST_SCAN;
         wba_pkg::ST_SCAN: begin
            if (pos_ff == LAST_POS) begin
               state_in = wba_pkg::ST_UPDATE;
            end
         end
         wba_pkg::ST_UPDATE: state_in = wba_pkg::ST_FINISH;
         wba_pkg::ST_FINISH: begin
            if (out_load) begin
               state_in = wba_pkg::ST_IDLE;
            end
         end
         default:            state_in = wba_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ram_rd_en      = 1'b0;
      load_row       = 1'b0;
      scan_ctl.clear = 1'b0;
      scan_ctl.step  = 1'b0;
      upd            = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         wba_pkg::ST_FETCH:  ram_rd_en = 1'b1;
         wba_pkg::ST_LOAD: begin
            load_row       = 1'b1;
            scan_ctl.clear = 1'b1;
         end
         wba_pkg::ST_SCAN:   scan_ctl.step = 1'b1;
         wba_pkg::ST_UPDATE: upd = 1'b1;
         wba_pkg::ST_FINISH: out_load = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == wba_pkg::REG_BUFFERS_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wba_pkg::BUFFERS_IN_USE_RESET;
      end else if (cfg_write) begin
         cfg_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == wba_pkg::REG_BUFFERS_IN_USE) begin
         csr_prdata = DATA_W'(cfg_ff);
      end
   end

   // clamp the rotation set size to 2..BUFFERS
   always_comb begin
      if (NW'(cfg_ff) < NW'(2)) begin
         active_n = NW'(2);
      end else if (NW'(cfg_ff) > NW'(BUFFERS)) begin
         active_n = NW'(BUFFERS);
      end else begin
         active_n = NW'(cfg_ff);
      end
   end

   // ------------------------------------------------------------------
   // request capture and row fetch
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_operation;
         chan_ff    <= req_channel;
         writer_ff  <= req_is_writer;
         written_ff <= req_has_written;
         held_ff    <= req_held_buffer;
      end
   end

   assign chan_wide = (CH_W + 3)'(chan_ff);
   assign ch_addr   = chan_wide[CH_W-1:0];

   for (genvar i = 0; i < BUFFERS; i++) begin : g_reset_row
      assign order_reset[i] = BUF_W'(i);
   end

   assign ram_wr_data = {new_count, new_order};

   wba_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CHANNELS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (upd),
      .wr_addr (ch_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ch_addr),
      .rd_data (ram_rd_data)
   );

   // a row never written reads as identity order with no holders
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (upd) begin
         row_valid_ff[ch_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_row) begin
         if (row_valid_ff[ch_addr]) begin
            order_ff <= ram_rd_data[ORDER_W-1:0];
            count_ff <= ram_rd_data[ROW_W-1:ORDER_W];
         end else begin
            order_ff <= order_reset;
            count_ff <= '0;
         end
      end
   end

   // advance the scan position
   always_ff @(posedge clock) begin
      if (load_row) begin
         pos_ff <= '0;
      end else if (scan_ctl.step) begin
         pos_ff <= pos_ff + BUF_W'(1);
      end
   end

   // ------------------------------------------------------------------
   // scan: one age order position per cycle
   // ------------------------------------------------------------------
   assign held_wide = (BUF_W + 2)'(held_ff);
   assign held_b    = held_wide[BUF_W-1:0];
   assign held_ok   = held_wide < (BUF_W + 2)'(BUFFERS);
   assign entry_buf = order_ff[pos_ff];

   // single count read port: scanned entry, then the buffer being updated
   assign cnt_addr = scan_ctl.step ? entry_buf : upd_sel;
   assign cnt_rd   = count_ff[cnt_addr];

   wba_scan #(
      .BUFFERS (BUFFERS)
   ) u_scan (
      .clock       (clock),
      .ctl         (scan_ctl),
      .active_n    (active_n),
      .entry_pos   (pos_ff),
      .entry_buf   (entry_buf),
      .entry_zero  (cnt_rd == '0),
      .target_buf  (held_b),
      .free_found  (free_found),
      .free_buf    (free_buf),
      .free_pos    (free_pos),
      .newest_buf  (newest_buf),
      .second_buf  (second_buf),
      .newest_zero (newest_zero),
      .match_pos   (match_pos)
   );

   // ------------------------------------------------------------------
   // update: decide, adjust the holder count, rotate the age order
   // ------------------------------------------------------------------
   assign wr_req     = writer_ff && written_ff;
   assign is_acq     = (op_ff == wba_pkg::OP_ACQUIRE);
   // reader takes the newest active buffer unless held, else the second newest
   assign reader_idx = newest_zero ? newest_buf : second_buf;
   assign upd_sel    = !is_acq ? held_b : (wr_req ? free_buf : reader_idx);
   assign sel_wide   = (BUF_W + 2)'(upd_sel);

   always_comb begin
      do_bump    = 1'b0;
      do_dec     = 1'b0;
      do_move    = 1'b0;
      move_pos   = free_pos;
      upd_idx    = res_idx_ff;
      upd_status = wba_pkg::STATUS_OK;
      if (is_acq) begin
         upd_idx = sel_wide[IDX_W-1:0];
         if (wr_req) begin
            if (free_found) begin
               do_bump = 1'b1;
               do_move = 1'b1;
            end else begin
               upd_idx    = '0;
               upd_status = wba_pkg::STATUS_NOFREE;
            end
         end else begin
            do_bump = 1'b1;
         end
      end else begin
         // release echoes the held index captured at the transfer
         if (held_ok && (cnt_rd != '0)) begin
            do_dec = 1'b1;
            if (wr_req) begin
               do_move  = 1'b1;
               move_pos = match_pos;
            end
         end else begin
            upd_status = wba_pkg::STATUS_UNHELD;
         end
      end
   end

   // saturate on acquire
   always_comb begin
      new_cnt = cnt_rd;
      if (do_bump && (cnt_rd != COUNT_MAX)) begin
         new_cnt = cnt_rd + COUNT_WIDTH'(1);
      end else if (do_dec) begin
         new_cnt = cnt_rd - COUNT_WIDTH'(1);
      end
   end

   for (genvar i = 0; i < BUFFERS; i++) begin : g_new_row
      assign new_count[i] = (upd_sel == BUF_W'(i)) ? new_cnt : count_ff[i];
      if (i < BUFFERS - 1) begin : g_shift
         // entries at and after the moved one shift one place older
         assign new_order[i] = (do_move && (BUF_W'(i) >= move_pos)) ?
                               order_ff[i+1] : order_ff[i];
      end else begin : g_tail
         assign new_order[i] = do_move ? upd_sel : order_ff[i];
      end
   end

   // ------------------------------------------------------------------
   // result hold and output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         // answer for a channel out of range; overwritten by the update
         if (req_operation == wba_pkg::OP_ACQUIRE) begin
            res_idx_ff    <= '0;
            res_status_ff <= wba_pkg::STATUS_NOFREE;
         end else begin
            res_idx_ff    <= req_held_buffer;
            res_status_ff <= wba_pkg::STATUS_UNHELD;
         end
      end else if (upd) begin
         res_idx_ff    <= upd_idx;
         res_status_ff <= upd_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_idx_ff    <= res_idx_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_buffer_index = rsp_idx_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
`default_nettype wire

// File: rtl/wba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wba_checker - port-level checks of the buffer allocator
// Watches the request and result channels of the top level.
// ---------------------------------------------------------------------------
module wba_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [wba_pkg::IDX_W-1:0]    rsp_buffer_index,
   input wire logic [wba_pkg::STATUS_W-1:0] rsp_status
);

   logic accept;

   assign accept = req_valid && !req_stall;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_buffer_index) &&
                                 $stable(rsp_status))
      else $error("stalled result changed");

   // one item at a time: block the request side after each transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted while busy");

   // with no result pending, none appears in the cycle right after a request transfer
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      accept && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

   // a failed acquire grants buffer zero
   a_nofree_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == wba_pkg::STATUS_NOFREE) |-> rsp_buffer_index == '0)
      else $error("no-free result with nonzero index");

   // drop any result at reset
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind waitfree_buffer_allocator_core wba_checker u_wba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_buffer_index (rsp_buffer_index),
   .rsp_status       (rsp_status)
);
`default_nettype wire
